>>> sv/phsm_pkg.sv
// shared types, constants and modular helpers of the polynomial hash matcher
`timescale 1ns / 1ps

package phsm_pkg;

    localparam int HASH_BITS  = 31;
    localparam int LEN_BITS   = 7;
    localparam int START_BITS = 32;

    localparam logic [HASH_BITS-1:0] HASH_MOD   = 31'd1234567891;
    localparam logic [HASH_BITS-1:0] HASH_BASE  = 31'd31;
    localparam logic [7:0]           DIGIT_ZERO = 8'd97;

    // barrett factor for 62-bit products
    localparam logic [31:0] BARRETT_MU = 32'((64'd1 << 62) / 64'(HASH_MOD));

    localparam int QUEUE_DEPTH = 4;

    typedef logic [HASH_BITS-1:0] residue_t;

    typedef enum logic [0:0] {
        CFG_PATTERN_HASH   = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } phsm_in_t;

    typedef struct packed {
        logic [START_BITS-1:0] match_start;
        logic                  too_short;
    } phsm_out_t;

    typedef struct packed {
        logic compare;
        logic too_short;
        logic last;
        logic old_cur;
        logic old_prev;
    } phsm_flags_t;

    typedef struct packed {
        residue_t              digit;
        residue_t              power;
        residue_t              old_power;
        logic [START_BITS-1:0] match_start;
        phsm_flags_t           flags;
    } phsm_item_t;

    // multiples of the modulus just below each 2^29 step of a 36-bit value
    typedef logic [35:0] red_tab_t [128];

    function automatic red_tab_t build_red_tab();
        red_tab_t tab;
        for (int j = 0; j < 128; j++) begin
            tab[j] = 36'(((64'(j) << 29) / 64'(HASH_MOD)) * 64'(HASH_MOD));
        end
        return tab;
    endfunction

    localparam red_tab_t RED_TAB = build_red_tab();

    function automatic residue_t mul_base_mod(input residue_t p);
        logic [35:0] prod;
        logic [35:0] rem;
        prod = 36'(p) * 36'(HASH_BASE);
        rem  = prod - RED_TAB[prod[35:29]];
        if (rem >= 36'(HASH_MOD)) begin
            rem = rem - 36'(HASH_MOD);
        end
        return rem[HASH_BITS-1:0];
    endfunction

    function automatic residue_t reduce_once(input residue_t x);
        residue_t r;
        r = x;
        if (x >= HASH_MOD) begin
            r = x - HASH_MOD;
        end
        return r;
    endfunction

endpackage

>>> sv/phsm_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module phsm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/phsm_fifo.sv
// short request queue between the front and back parts
`timescale 1ns / 1ps

module phsm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/phsm_mulmod.sv
// four stage modular multiplier: product, barrett quotient, remainder, correction
`timescale 1ns / 1ps

module phsm_mulmod
    import phsm_pkg::*;
(
    input  logic     aclk,
    input  logic     en,
    input  residue_t a,
    input  residue_t b,
    output residue_t r
);

    localparam logic [32:0] MOD_W  = 33'(HASH_MOD);
    localparam logic [32:0] MOD_X2 = MOD_W << 1;

    logic [61:0] prod_reg;
    logic [31:0] quot_reg;
    logic [32:0] low_reg;
    logic [32:0] rem_reg;
    residue_t    res_reg;

    logic [63:0] quot_full;
    logic [63:0] qp_full;
    residue_t    res_next;

    assign quot_full = 64'(prod_reg[61:30]) * 64'(BARRETT_MU);
    assign qp_full   = 64'(quot_reg) * 64'(HASH_MOD);

    // quotient estimate is at most two short, so remainder stays below 3p
    always_comb begin
        if (rem_reg >= MOD_X2) begin
            res_next = HASH_BITS'(rem_reg - MOD_X2);
        end else if (rem_reg >= MOD_W) begin
            res_next = HASH_BITS'(rem_reg - MOD_W);
        end else begin
            res_next = HASH_BITS'(rem_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 62'(a) * 62'(b);
            quot_reg <= quot_full[63:32];
            low_reg  <= prod_reg[32:0];
            rem_reg  <= low_reg - qp_full[32:0];
            res_reg  <= res_next;
        end
    end

    assign r = res_reg;

endmodule

>>> sv/phsm_front.sv
// front part: digit, running power, position count and power ring lookup
`timescale 1ns / 1ps

module phsm_front
    import phsm_pkg::*;
#(
    parameter int WINDOW_DEPTH  = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  phsm_in_t                        s_data,
    input  logic [LEN_BITS-1:0]             pattern_length,
    output logic                            q_valid,
    input  logic                            q_full,
    output phsm_item_t                      q_item,
    output logic [$clog2(WINDOW_DEPTH)-1:0] q_wptr,
    output logic [$clog2(WINDOW_DEPTH)-1:0] q_slot
);

    localparam int RING_BITS = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS  = RING_BITS + 2;
    localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

    residue_t                 power_reg, power_next;
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [RING_BITS-1:0]     ptr_reg, ptr_next;
    logic                     f1_valid_reg, f1_valid_next;
    phsm_item_t               f1_item_reg, f1_item_next;
    logic [RING_BITS-1:0]     f1_wptr_reg, f1_slot_reg;

    logic                     accept;
    logic [POSITION_BITS-1:0] count_inc;
    logic [SUM_BITS-1:0]      slot_sum;
    logic [RING_BITS-1:0]     slot;
    residue_t                 digit;
    residue_t                 ring_rd_data;
    logic                     compare;

    assign s_ready = !f1_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign compare   = (count_inc >= POSITION_BITS'(pattern_length));

    // window start slot, one past the write pointer minus the length, modulo the depth
    assign slot_sum = SUM_BITS'(ptr_reg) + SUM_BITS'(WINDOW_DEPTH + 1)
                    - SUM_BITS'(pattern_length);
    assign slot = (slot_sum >= SUM_BITS'(WINDOW_DEPTH))
                ? RING_BITS'(slot_sum - SUM_BITS'(WINDOW_DEPTH))
                : RING_BITS'(slot_sum);

    // bytes below 'a' give the negative digit as its residue
    assign digit = (s_data.text_byte >= DIGIT_ZERO)
                 ? HASH_BITS'(s_data.text_byte - DIGIT_ZERO)
                 : HASH_MOD - HASH_BITS'(DIGIT_ZERO) + HASH_BITS'(s_data.text_byte);

    always_comb begin
        power_next = power_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        if (accept) begin
            if (s_data.end_of_text) begin
                power_next = HASH_BITS'(1);
                count_next = '0;
                ptr_next   = '0;
            end else begin
                power_next = mul_base_mod(power_reg);
                count_next = count_inc;
                ptr_next   = (ptr_reg == RING_BITS'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_comb begin
        f1_valid_next = f1_valid_reg;
        if (s_ready) begin
            f1_valid_next = s_valid;
        end
        f1_item_next.digit           = digit;
        f1_item_next.power           = power_reg;
        f1_item_next.old_power       = '0;
        f1_item_next.match_start     = START_BITS'(count_inc - POSITION_BITS'(pattern_length)
                                                   + 1'b1);
        f1_item_next.flags.compare   = compare;
        f1_item_next.flags.too_short = !compare && s_data.end_of_text;
        f1_item_next.flags.last      = s_data.end_of_text;
        f1_item_next.flags.old_cur   = (pattern_length == LEN_BITS'(1));
        f1_item_next.flags.old_prev  = (pattern_length == LEN_BITS'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg    <= HASH_BITS'(1);
            count_reg    <= '0;
            ptr_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            power_reg    <= power_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_item_reg <= f1_item_next;
            f1_wptr_reg <= ptr_reg;
            f1_slot_reg <= slot;
        end
    end

    // power before each byte, read back at the window start
    phsm_ram #(
        .WIDTH(HASH_BITS),
        .DEPTH(WINDOW_DEPTH)
    ) u_power_ring (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (ptr_reg),
        .wr_data (power_reg),
        .rd_en   (accept),
        .rd_addr (slot),
        .rd_data (ring_rd_data)
    );

    // length one needs the entry written on the same edge, so it takes the item's own power
    always_comb begin
        q_item           = f1_item_reg;
        q_item.old_power = f1_item_reg.flags.old_cur ? f1_item_reg.power : ring_rd_data;
    end

    assign q_valid = f1_valid_reg;
    assign q_wptr  = f1_wptr_reg;
    assign q_slot  = f1_slot_reg;

endmodule

>>> sv/phsm_back.sv
// back part: digit and target products, running hash, hash ring and window compare
`timescale 1ns / 1ps

module phsm_back
    import phsm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  phsm_item_t                      q_item,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] q_wptr,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] q_slot,
    input  residue_t                        pattern_hash,
    output logic                            m_valid,
    input  logic                            m_ready,
    output phsm_out_t                       m_data
);

    localparam int RING_BITS = $clog2(WINDOW_DEPTH);
    localparam int STAGES    = 4;

    logic [STAGES-1:0]     v_reg;
    phsm_flags_t           flags_reg [STAGES];
    logic [START_BITS-1:0] start_reg [STAGES];
    logic [RING_BITS-1:0]  wptr_reg  [STAGES];
    logic [RING_BITS-1:0]  slot_reg  [STAGES];

    residue_t              hash_reg, hash_next;
    residue_t              prev_hash_reg;
    logic                  v5_reg;
    residue_t              h5_reg, old5_reg, target5_reg;
    phsm_flags_t           flags5_reg;
    logic [START_BITS-1:0] start5_reg;
    logic                  m_valid_reg;
    phsm_out_t             m_data_reg, m_data_next;

    logic                  adv;
    residue_t              term, target, ring_hash, old_hash;
    logic [HASH_BITS:0]    hash_sum;
    residue_t              window;
    logic                  hit;

    // whole back pipeline moves unless a result waits at the output
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    phsm_mulmod u_term (
        .aclk (aclk),
        .en   (adv),
        .a    (q_item.digit),
        .b    (q_item.power),
        .r    (term)
    );

    phsm_mulmod u_target (
        .aclk (aclk),
        .en   (adv),
        .a    (pattern_hash),
        .b    (q_item.old_power),
        .r    (target)
    );

    // prefix hash before each byte; read as the request enters the last stage
    phsm_ram #(
        .WIDTH(HASH_BITS),
        .DEPTH(WINDOW_DEPTH)
    ) u_hash_ring (
        .aclk    (aclk),
        .wr_en   (adv && v_reg[STAGES-1]),
        .wr_addr (wptr_reg[STAGES-1]),
        .wr_data (hash_reg),
        .rd_en   (adv && v_reg[STAGES-2]),
        .rd_addr (slot_reg[STAGES-2]),
        .rd_data (ring_hash)
    );

    assign hash_sum  = {1'b0, hash_reg} + {1'b0, term};
    assign hash_next = (hash_sum >= {1'b0, HASH_MOD})
                     ? HASH_BITS'(hash_sum - {1'b0, HASH_MOD})
                     : HASH_BITS'(hash_sum);

    // lengths one and two need entries the ring cannot return yet
    always_comb begin
        if (flags_reg[STAGES-1].old_cur) begin
            old_hash = hash_reg;
        end else if (flags_reg[STAGES-1].old_prev) begin
            old_hash = prev_hash_reg;
        end else begin
            old_hash = ring_hash;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            v5_reg      <= 1'b0;
            hash_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg       <= {v_reg[STAGES-2:0], !q_empty};
            v5_reg      <= v_reg[STAGES-1];
            m_valid_reg <= hit;
            if (v_reg[STAGES-1]) begin
                hash_reg <= flags_reg[STAGES-1].last ? '0 : hash_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            flags_reg[0] <= q_item.flags;
            start_reg[0] <= q_item.match_start;
            wptr_reg[0]  <= q_wptr;
            slot_reg[0]  <= q_slot;
            for (int i = 1; i < STAGES; i++) begin
                flags_reg[i] <= flags_reg[i-1];
                start_reg[i] <= start_reg[i-1];
                wptr_reg[i]  <= wptr_reg[i-1];
                slot_reg[i]  <= slot_reg[i-1];
            end
            if (v_reg[STAGES-1]) begin
                prev_hash_reg <= hash_reg;
            end
            h5_reg      <= hash_next;
            old5_reg    <= old_hash;
            target5_reg <= target;
            flags5_reg  <= flags_reg[STAGES-1];
            start5_reg  <= start_reg[STAGES-1];
            m_data_reg  <= m_data_next;
        end
    end

    assign window = (h5_reg >= old5_reg) ? h5_reg - old5_reg : h5_reg + HASH_MOD - old5_reg;
    assign hit    = v5_reg && ((flags5_reg.compare && (window == target5_reg))
                               || flags5_reg.too_short);

    always_comb begin
        m_data_next.too_short   = flags5_reg.too_short;
        m_data_next.match_start = flags5_reg.too_short ? '0 : start5_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/polynomial_hash_substring_matcher.sv
// top level of the polynomial hash substring matcher: registers, front, queue, back
//
// channel  dir  handshake         payload
// s_       in   s_valid/s_ready   phsm_in_t  text_byte, end_of_text
// m_       out  m_valid/m_ready   phsm_out_t match_start, too_short
// cfg_     in   cfg_wr_en         cfg_index, cfg_wr_data (no wait)
//
// one byte per clock sustained unless a result waits on m_ready
// the rate is set by the combinational running power step and running hash add
// products go through two shared-shape 4-stage barrett multipliers
// reset clears control state only; the rings are filled by the text, no clearing pass
// m_ready low on a result freezes the back; the 4-entry queue fills, s_ready drops
`timescale 1ns / 1ps

module polynomial_hash_substring_matcher
    import phsm_pkg::*;
#(
    parameter int WINDOW_DEPTH  = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  phsm_in_t       s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output phsm_out_t      m_data,
    input  logic           cfg_wr_en,
    input  cfg_index_t     cfg_index,
    input  logic [30:0]    cfg_wr_data
);

    localparam int RING_BITS  = $clog2(WINDOW_DEPTH);
    localparam int ITEM_BITS  = $bits(phsm_item_t) + 2 * RING_BITS;

    residue_t              pattern_hash_reg;
    logic [LEN_BITS-1:0]   pattern_length_reg;
    logic [LEN_BITS-1:0]   length_next;

    logic                  f_valid;
    phsm_item_t            f_item;
    logic [RING_BITS-1:0]  f_wptr, f_slot;
    logic                  q_full, q_empty, q_pop;
    logic [ITEM_BITS-1:0]  q_push_data, q_pop_data;
    phsm_item_t            b_item;
    logic [RING_BITS-1:0]  b_wptr, b_slot;

    // zero length acts as one, longer than the ring acts as the ring depth
    always_comb begin
        length_next = cfg_wr_data[LEN_BITS-1:0];
        if (cfg_wr_data[LEN_BITS-1:0] == '0) begin
            length_next = LEN_BITS'(1);
        end else if (int'(cfg_wr_data[LEN_BITS-1:0]) > WINDOW_DEPTH) begin
            length_next = LEN_BITS'(WINDOW_DEPTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_hash_reg   <= '0;
            pattern_length_reg <= LEN_BITS'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PATTERN_HASH: begin
                    pattern_hash_reg <= reduce_once(cfg_wr_data);
                end
                CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= length_next;
                end
            endcase
        end
    end

    phsm_front #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .pattern_length (pattern_length_reg),
        .q_valid        (f_valid),
        .q_full         (q_full),
        .q_item         (f_item),
        .q_wptr         (f_wptr),
        .q_slot         (f_slot)
    );

    assign q_push_data = {f_item, f_wptr, f_slot};

    phsm_fifo #(
        .WIDTH (ITEM_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    assign {b_item, b_wptr, b_slot} = q_pop_data;

    phsm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_item       (b_item),
        .q_wptr       (b_wptr),
        .q_slot       (b_slot),
        .pattern_hash (pattern_hash_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

>>> test/tb_polynomial_hash_substring_matcher.sv
// self-checking testbench of the polynomial hash substring matcher
`timescale 1ns / 1ps

module tb_polynomial_hash_substring_matcher
    import phsm_pkg::*;
();

    localparam int          WINDOW      = 64;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE_GAP  = 16;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 110;
    localparam longint unsigned PRIME     = 64'(HASH_MOD);
    localparam longint unsigned BASE_MUL  = 64'(HASH_BASE);
    localparam longint unsigned COUNT_TOP = 64'hFFFF_FFFF;

    typedef enum logic [0:0] {
        ROW_BYTE = 1'b0,
        ROW_REGS = 1'b1
    } row_kind_t;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_QUIET = 2'd1,
        CHK_GIVEN = 2'd2
    } check_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  text_byte;
        logic        end_of_text;
        logic [30:0] hash_val;
        logic [30:0] len_val;
        check_t      check;
        phsm_out_t   want;
    } row_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    phsm_in_t   s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    phsm_out_t  m_data;
    logic       cfg_wr_en   = 1'b0;
    cfg_index_t cfg_index   = CFG_PATTERN_HASH;
    logic [30:0] cfg_wr_data = '0;

    // predictor copy of registers and text state
    logic [30:0]     cfg_hash;
    logic [6:0]      cfg_len;
    logic [30:0]     run_hash;
    logic [30:0]     run_pow;
    longint unsigned char_cnt;
    int unsigned     ring_wr;
    logic [30:0]     hash_hist [WINDOW];
    logic [30:0]     pow_hist  [WINDOW];

    phsm_out_t report_q [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int send_pct    = 0;
    int recv_pct    = 0;
    int hold_cycles = 0;

    row_t       plan [32];
    int         n_rows;
    logic [7:0] pat_bytes [WINDOW];
    logic [7:0] text_buf  [256];
    int         phase_len [PHASES] = '{1, 3, 2, 0, 5, 64, 8, 127, 16, 100};

    polynomial_hash_substring_matcher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned digit_of(input logic [7:0] b);
        if (b >= DIGIT_ZERO) begin
            return 64'(b) - 64'(DIGIT_ZERO);
        end
        return PRIME - (64'(DIGIT_ZERO) - 64'(b));
    endfunction

    function automatic int eff_len(input logic [6:0] l);
        if (l == 0) begin
            return 1;
        end
        if (int'(l) > WINDOW) begin
            return WINDOW;
        end
        return int'(l);
    endfunction

    function automatic logic [30:0] pattern_sum(input int n);
        longint unsigned acc;
        longint unsigned pw;
        acc = 0;
        pw  = 1;
        for (int j = 0; j < n; j++) begin
            acc = (digit_of(pat_bytes[j]) * pw + acc) % PRIME;
            pw  = (pw * BASE_MUL) % PRIME;
        end
        return 31'(acc);
    endfunction

    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return 8'd97 + 8'($urandom_range(2));
        end else if (r < 85) begin
            return 8'($urandom_range(255));
        end
        return 8'($urandom_range(96));
    endfunction

    task automatic restart_text();
        run_hash = '0;
        run_pow  = 31'd1;
        char_cnt = 0;
        ring_wr  = 0;
    endtask

    // one byte through the predictor: returns whether a report comes out
    task automatic scan_byte(input phsm_in_t b, output bit found, output phsm_out_t rep);
        longint unsigned k;
        longint unsigned slot;
        longint unsigned h;
        longint unsigned p;
        longint unsigned win;
        longint unsigned tgt;
        k = longint'(eff_len(cfg_len));
        found = 1'b0;
        rep   = '0;
        hash_hist[ring_wr] = run_hash;
        pow_hist[ring_wr]  = run_pow;
        h = 64'(run_hash);
        p = 64'(run_pow);
        run_hash = 31'((digit_of(b.text_byte) * p + h) % PRIME);
        run_pow  = 31'((p * BASE_MUL) % PRIME);
        if (char_cnt < COUNT_TOP) begin
            char_cnt++;
        end
        if (char_cnt >= k) begin
            slot = (64'(ring_wr) + WINDOW + 1 - k) % WINDOW;
            win  = (64'(run_hash) + PRIME - 64'(hash_hist[slot])) % PRIME;
            tgt  = ((64'(cfg_hash) % PRIME) * 64'(pow_hist[slot])) % PRIME;
            if (win == tgt) begin
                rep.match_start = 32'(char_cnt - k + 1);
                rep.too_short   = 1'b0;
                found = 1'b1;
            end
        end else if (b.end_of_text) begin
            rep.match_start = '0;
            rep.too_short   = 1'b1;
            found = 1'b1;
        end
        ring_wr = (ring_wr + 1) % WINDOW;
        if (b.end_of_text) begin
            restart_text();
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eot, input check_t chk,
                             input phsm_out_t want);
        phsm_in_t  req;
        bit        found;
        phsm_out_t rep;
        req.text_byte   = b;
        req.end_of_text = eot;
        if ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(req, found, rep);
        if (chk == CHK_GIVEN) begin
            report_q = {report_q, want};
        end else if (chk == CHK_MODEL && found) begin
            report_q = {report_q, rep};
        end
    endtask

    // stop sending and wait until every report is out and the pipeline is empty
    task automatic settle();
        s_valid <= 1'b0;
        recv_pct = 0;
        do @(posedge aclk); while (report_q.size() != 0);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [30:0] hash_val, input logic [30:0] len_val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_PATTERN_HASH;
        cfg_wr_data <= hash_val;
        @(posedge aclk);
        cfg_index   <= CFG_PATTERN_LENGTH;
        cfg_wr_data <= len_val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_hash = hash_val;
        cfg_len  = len_val[6:0];
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eot, input check_t chk,
                            input logic [31:0] start, input logic short);
        plan[n_rows] = '{kind: ROW_BYTE, text_byte: b, end_of_text: eot, hash_val: '0,
                         len_val: '0, check: chk,
                         want: '{match_start: start, too_short: short}};
        n_rows++;
    endtask

    task automatic add_regs(input logic [30:0] hash_val, input logic [30:0] len_val);
        plan[n_rows] = '{kind: ROW_REGS, text_byte: '0, end_of_text: 1'b0,
                         hash_val: hash_val, len_val: len_val, check: CHK_MODEL,
                         want: '0};
        n_rows++;
    endtask

    task automatic run_phase(input int len_cfg, input int items, input int s_pct,
                             input int r_pct);
        int          ke;
        int          sent;
        int          tlen;
        int          r;
        int          pos;
        bit          ends;
        bit          paused;
        logic [30:0] h;
        settle();
        ke = eff_len(7'(len_cfg));
        for (int j = 0; j < ke; j++) begin
            pat_bytes[j] = filler_byte();
        end
        h = pattern_sum(ke);
        // same residue through an alias above the modulus
        if (h < 31'h7FFF_FFFF - HASH_MOD && $urandom_range(2) == 0) begin
            h = h + HASH_MOD;
        end
        write_regs(h, {24'($urandom), 7'(len_cfg)});
        send_pct = s_pct;
        recv_pct = r_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < items) begin
            r = $urandom_range(99);
            ends = ($urandom_range(99) >= 15);
            if (r < 10) begin
                tlen = $urandom_range(20, 1);
                for (int j = 0; j < tlen; j++) begin
                    text_buf[j] = 8'($urandom_range(255));
                end
            end else if (r < 22) begin
                tlen = $urandom_range(ke, 1);
                ends = 1'b1;
                for (int j = 0; j < tlen; j++) begin
                    text_buf[j] = filler_byte();
                end
            end else begin
                tlen = $urandom_range(2 * ke + 8, ke);
                for (int j = 0; j < tlen; j++) begin
                    text_buf[j] = filler_byte();
                end
                repeat ($urandom_range(2, 1)) begin
                    pos = $urandom_range(tlen - ke, 0);
                    for (int j = 0; j < ke; j++) begin
                        text_buf[pos + j] = pat_bytes[j];
                    end
                end
            end
            for (int j = 0; j < tlen; j++) begin
                // sender waits mid-text until all reports have come back
                if (!paused && sent >= items / 2) begin
                    paused = 1'b1;
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (report_q.size() != 0);
                end
                push_byte(text_buf[j], ends && (j == tlen - 1), CHK_MODEL, '0);
                sent++;
            end
        end
    endtask

    // result side: compare in order, drive random stalls and long hold-offs
    always @(posedge aclk) begin
        phsm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $error("unexpected result: match_start %0d too_short %0d",
                       m_data.match_start, m_data.too_short);
                fail_count++;
            end else begin
                want = report_q.pop_front();
                if (m_data.match_start !== want.match_start) begin
                    $error("match_start: expected %0d, got %0d",
                           want.match_start, m_data.match_start);
                    fail_count++;
                end
                if (m_data.too_short !== want.too_short) begin
                    $error("too_short: expected %0d, got %0d",
                           want.too_short, m_data.too_short);
                    fail_count++;
                end
            end
        end
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        cfg_hash = '0;
        cfg_len  = 7'd1;
        for (int j = 0; j < WINDOW; j++) begin
            hash_hist[j] = '0;
            pow_hist[j]  = '0;
        end
        restart_text();

        n_rows = 0;
        // reset registers: empty pattern hash, length one, so 'a' matches alone
        add_byte(8'h61, 1'b0, CHK_GIVEN, 32'd1, 1'b0);
        add_byte(8'h62, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h61, 1'b0, CHK_GIVEN, 32'd3, 1'b0);
        add_byte(8'h00, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'hFF, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h61, 1'b1, CHK_GIVEN, 32'd6, 1'b0);
        add_byte(8'h61, 1'b1, CHK_GIVEN, 32'd1, 1'b0);
        // length above window depth clamps, hash above the modulus folds
        add_regs(31'h7FFF_FFFF, 31'd127);
        add_byte(8'h61, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h7A, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h80, 1'b1, CHK_GIVEN, 32'd0, 1'b1);
        // zero length acts as one; digits below 'a' wrap to the top residues
        add_regs(HASH_MOD - 31'd1, 31'h7FFF_FF80);
        add_byte(8'h60, 1'b0, CHK_GIVEN, 32'd1, 1'b0);
        add_byte(8'h60, 1'b1, CHK_MODEL, 32'd0, 1'b0);
        add_byte(8'h61, 1'b1, CHK_QUIET, 32'd0, 1'b0);
        // pattern "abc"
        add_regs(31'd1953, 31'd3);
        add_byte(8'h78, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h61, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h62, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h63, 1'b0, CHK_MODEL, 32'd0, 1'b0);
        add_byte(8'h61, 1'b0, CHK_MODEL, 32'd0, 1'b0);
        add_byte(8'h62, 1'b1, CHK_MODEL, 32'd0, 1'b0);
        add_byte(8'h71, 1'b1, CHK_GIVEN, 32'd0, 1'b1);
        add_regs(HASH_MOD, 31'h7FFF_FF82);
        add_byte(8'h61, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'h61, 1'b1, CHK_GIVEN, 32'd1, 1'b0);
        add_byte(8'h00, 1'b0, CHK_QUIET, 32'd0, 1'b0);
        add_byte(8'hFF, 1'b1, CHK_MODEL, 32'd0, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < n_rows; i++) begin
            if (plan[i].kind == ROW_REGS) begin
                settle();
                write_regs(plan[i].hash_val, plan[i].len_val);
            end else begin
                push_byte(plan[i].text_byte, plan[i].end_of_text, plan[i].check,
                          plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: run_phase(phase_len[p], PHASE_ITEMS, 0, 0);
                1: run_phase(phase_len[p], PHASE_ITEMS, 68, 0);
                2: run_phase(phase_len[p], PHASE_ITEMS, 0, 68);
                default: run_phase(phase_len[p], PHASE_ITEMS, 29, 29);
            endcase
            if (p == 4) begin
                // mostly 'a' bytes, which match, while the receiver holds off: queue fills
                settle();
                write_regs('0, 31'd1);
                send_pct = 0;
                hold_cycles = 300;
                for (int j = 0; j < 80; j++) begin
                    push_byte(($urandom_range(3) == 0) ? filler_byte() : 8'h61,
                              j == 79, CHK_MODEL, '0);
                end
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (report_q.size() != 0);
        repeat (2 * SETTLE_GAP) @(posedge aclk);
        if (report_q.size() != 0) begin
            $error("%0d reports never arrived", report_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/phsm_pkg.sv
sv/phsm_ram.sv
sv/phsm_fifo.sv
sv/phsm_mulmod.sv
sv/phsm_front.sv
sv/phsm_back.sv
sv/polynomial_hash_substring_matcher.sv
test/tb_polynomial_hash_substring_matcher.sv
